// ----- sv/tlpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and codes of the two-level priority queue
// Command and result structs, status and command codes, the stored word
// layout.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    // Default number of queue places
    localparam int DEPTH_DEF = 128;

    // Field widths
    localparam int ID_W     = 31;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 3;
    localparam int OLEVEL_W = 2;
    // Stored word: bit 31 set for priority 2, bits 30..0 the identifier
    localparam int ENTRY_W  = ID_W + 1;

    // Command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Priority levels
    localparam logic [LEVEL_W-1:0] LEVEL_HI = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] LEVEL_LO = LEVEL_W'(2);
    localparam logic [OLEVEL_W-1:0] OLEVEL_HI = OLEVEL_W'(1);
    localparam logic [OLEVEL_W-1:0] OLEVEL_LO = OLEVEL_W'(2);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ADDED   = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_FULL    = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_BADPRI  = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_REMOVED = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_EMPTY   = STATUS_W'(4);

    typedef struct packed {
        logic               cmd;
        logic [ID_W-1:0]    entry_id;
        logic [LEVEL_W-1:0] level;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [OLEVEL_W-1:0] out_level;
    } t_result;

endpackage

// ----- sv/tlpq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/two_level_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_priority_queue: stable two-level priority queue of entry IDs
// Priority 1 entries leave before priority 2 entries, equal priorities leave
// in arrival order. Entries sit sorted in a circular RAM starting at the head.
//
//   Channel   Ports                      Transfer
//   command   i_start, i_cmd, o_busy     i_start high while o_busy low
//   result    o_done, o_result           o_done high for one cycle
//
// A remove passes S_REM; a rejected or empty command ends in S_IDLE. An add to
// an empty queue goes to S_ADD_PUT; any other add passes S_ADD_RD, then one
// S_ADD_CHK step per priority 2 entry moved back behind a new priority 1 entry,
// then a last S_ADD_CHK or S_ADD_PUT write; the single read port sets the pace.
// The result appears in the cycle after the command finishes.
// Reset clears head, occupancy and control; RAM contents need no clearing.
// The receiver cannot stall; every result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module two_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CHK,
        S_ADD_PUT,
        S_REM
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_occ, n_occ;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_wp, n_wp;
    logic [AW-1:0]        r_rp, n_rp;
    logic [ENTRY_W-1:0]   r_word, n_word;
    logic                 r_done, n_done;
    t_result              r_res, n_res;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [SW-1:0]        tail_sum;
    logic [AW-1:0]        tail;
    logic [AW-1:0]        tail_dec;
    logic [AW-1:0]        rp_dec;
    logic [AW-1:0]        head_inc;
    logic                 is_full;
    logic                 must_shift;

    tlpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Circular pointer arithmetic
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_occ);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        tail     = AW'(tail_sum);
        tail_dec = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
        rp_dec   = (r_rp == '0) ? AW'(DEPTH - 1) : r_rp - AW'(1);
        head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    end

    assign is_full    = (r_occ == CW'(DEPTH));
    // A stored priority 2 entry moves back behind a new priority 1 entry
    assign must_shift = ram_rdata[ENTRY_W-1] && !r_word[ENTRY_W-1];

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_occ     = r_occ;
        n_cnt     = r_cnt;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_word    = r_word;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = r_word;
        ram_raddr = r_rp;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = r_head;
                if (i_start) begin
                    n_res = '0;
                    if (i_cmd.cmd == CMD_REMOVE) begin
                        if (r_occ == '0) begin
                            n_res.status = ST_EMPTY;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_REM;
                        end
                    end else if (is_full) begin
                        n_res.status = ST_FULL;
                        n_done       = 1'b1;
                    end else if (i_cmd.level != LEVEL_HI && i_cmd.level != LEVEL_LO) begin
                        n_res.status = ST_BADPRI;
                        n_done       = 1'b1;
                    end else begin
                        n_word  = {i_cmd.level == LEVEL_LO, i_cmd.entry_id};
                        n_cnt   = r_occ;
                        n_wp    = tail;
                        n_rp    = tail_dec;
                        n_state = (r_occ == '0) ? S_ADD_PUT : S_ADD_RD;
                    end
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_CHK;
            end
            S_ADD_CHK: begin
                ram_we = 1'b1;
                if (must_shift) begin
                    // Move the entry back one place and fetch the next one
                    ram_wdata = ram_rdata;
                    ram_raddr = rp_dec;
                    n_wp      = r_rp;
                    n_rp      = rp_dec;
                    n_cnt     = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_ADD_PUT;
                    end
                end else begin
                    n_occ        = r_occ + CW'(1);
                    n_res.status = ST_ADDED;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ADD_PUT: begin
                ram_we       = 1'b1;
                n_occ        = r_occ + CW'(1);
                n_res.status = ST_ADDED;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_REM: begin
                n_res.status    = ST_REMOVED;
                n_res.out_id    = ram_rdata[ID_W-1:0];
                n_res.out_level = ram_rdata[ENTRY_W-1] ? OLEVEL_LO : OLEVEL_HI;
                n_occ           = r_occ - CW'(1);
                n_head          = (r_occ == CW'(1)) ? '0 : head_inc;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_res   <= n_res;
        end
        r_wp   <= n_wp;
        r_rp   <= n_rp;
        r_word <= n_word;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // Occupancy never exceeds the store
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    // An accepted command either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted command produced nothing");

    // A removed entry carries a valid priority
    a_removed_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_REMOVED) |->
            (o_result.out_level == OLEVEL_HI || o_result.out_level == OLEVEL_LO))
        else $error("removed entry with bad priority");

    // Results other than a removal carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_REMOVED) |->
            (o_result.out_id == '0 && o_result.out_level == '0))
        else $error("nonzero payload on non-remove result");

    // Empty is reported only with no entries stored
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (r_occ == '0))
        else $error("empty reported with entries stored");

endmodule

// ----- sim/two_level_priority_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_priority_queue_test: self-checking bench of the two-level queue
// A queue of commands (directed corners, then random add/remove traffic with
// fill and drain runs) feeds a clocked driver that idles in short bursts. A
// behavioral queue model predicts every result at command transfer, and a
// clocked monitor checks each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module two_level_priority_queue_test;
    import tlpq_pkg::*;

    localparam int DEPTH_Q      = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 60;
    localparam int SHOW_MAX     = 10;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    // Behavioral queue: stored word is {priority 2 flag, identifier}
    logic [ENTRY_W-1:0] queue_store [DEPTH_Q];
    int                 q_head  = 0;
    int                 q_count = 0;

    t_cmd    cmds_pending [$];
    t_result results_due  [$];

    int gen_count     = 0;
    int sent_count    = 0;
    int gap_left      = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int cycle_count   = 0;
    int cycle_limit   = 2000000;
    int adds_done     = 0;
    int removes_done  = 0;
    int full_hits     = 0;
    int badpri_hits   = 0;
    int empty_hits    = 0;
    int max_shift     = 0;
    int max_fill      = 0;

    two_level_priority_queue #(
        .DEPTH(DEPTH_Q)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int place_of(input int k);
        return (q_head + k) % DEPTH_Q;
    endfunction

    // Advance the queue model by one command and return its result
    task automatic queue_model_step(input t_cmd c, output t_result r);
        logic [ENTRY_W-1:0] word;
        logic [ENTRY_W-1:0] prev;
        int                 k;
        bit                 moving;
        r = '0;
        if (c.cmd == CMD_ADD) begin
            if (q_count >= DEPTH_Q) begin
                r.status = ST_FULL;
                full_hits++;
            end else if (c.level != LEVEL_HI && c.level != LEVEL_LO) begin
                r.status = ST_BADPRI;
                badpri_hits++;
            end else begin
                word   = {c.level == LEVEL_LO, c.entry_id};
                k      = q_count;
                moving = 1'b1;
                // Push worse-priority entries one place back from the tail
                while (k > 0 && moving) begin
                    prev = queue_store[place_of(k - 1)];
                    if (prev[ENTRY_W-1] && !word[ENTRY_W-1]) begin
                        queue_store[place_of(k)] = prev;
                        k--;
                    end else begin
                        moving = 1'b0;
                    end
                end
                if (q_count - k > max_shift) max_shift = q_count - k;
                queue_store[place_of(k)] = word;
                q_count++;
                if (q_count > max_fill) max_fill = q_count;
                r.status = ST_ADDED;
                adds_done++;
            end
        end else if (q_count == 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
        end else begin
            word        = queue_store[place_of(0)];
            r.status    = ST_REMOVED;
            r.out_id    = word[ID_W-1:0];
            r.out_level = word[ENTRY_W-1] ? OLEVEL_LO : OLEVEL_HI;
            q_count--;
            q_head      = (q_count == 0) ? 0 : place_of(1);
            removes_done++;
        end
    endtask

    // Append one command, tracking the fill level it leaves behind
    task automatic queue_cmd(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [LEVEL_W-1:0] lvl);
        t_cmd c;
        c.cmd      = cmd;
        c.entry_id = id;
        c.level    = lvl;
        cmds_pending.push_back(c);
        if (cmd == CMD_ADD) begin
            if (gen_count < DEPTH_Q && (lvl == LEVEL_HI || lvl == LEVEL_LO)) gen_count++;
        end else if (gen_count > 0) begin
            gen_count--;
        end
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level(input int lo_pct, input int bad_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < bad_pct) return LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
        return ($urandom_range(0, 99) < lo_pct) ? LEVEL_LO : LEVEL_HI;
    endfunction

    // Random add/remove traffic with the given add share
    task automatic queue_mix(input int n, input int add_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < add_pct)
                queue_cmd(CMD_ADD, ID_W'($urandom()), pick_level(50, 10));
            else
                queue_cmd(CMD_REMOVE, ID_W'($urandom()), LEVEL_W'($urandom()));
        end
    endtask

    // Drive commands; hold start until the transfer, idle in short bursts
    always @(posedge i_clk) begin : drive
        logic    next_start;
        t_result res;
        next_start = i_start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                queue_model_step(cmds_pending[0], res);
                results_due.push_back(res);
                cmds_pending.pop_front();
                sent_count++;
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmds_pending.size() > 0) begin
                    if (cmds_pending.size() > QUIET_ITEMS && (sent_count / 40) % 3 != 2
                            && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(0, 2);
                    end else begin
                        next_start = 1'b1;
                        i_cmd <= cmds_pending[0];
                    end
                end
            end
        end
        i_start <= next_start;
    end

    // Check each result strobe against the oldest prediction
    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("[%0t] unexpected result: status %0d id %h level %0d",
                             $realtime, o_result.status, o_result.out_id,
                             o_result.out_level);
            end else begin
                want = results_due.pop_front();
                checked_count++;
                if (o_result.status !== want.status || o_result.out_id !== want.out_id
                        || o_result.out_level !== want.out_level) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("[%0t] result %0d: expected status %0d id %h level %0d, got status %0d id %h level %0d",
                                 $realtime, checked_count, want.status, want.out_id,
                                 want.out_level, o_result.status, o_result.out_id,
                                 o_result.out_level);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= cycle_limit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("two_level_priority_queue regression: fail");
            $finish;
        end
    end

    initial begin
        // Directed corners: empty pop, bad levels, extreme ids, reorder, drain
        queue_cmd(CMD_REMOVE, '1, '1);
        queue_cmd(CMD_ADD, '0, LEVEL_LO);
        queue_cmd(CMD_ADD, '1, LEVEL_HI);
        queue_cmd(CMD_ADD, '1, LEVEL_W'(0));
        queue_cmd(CMD_ADD, '0, LEVEL_W'(3));
        queue_cmd(CMD_ADD, '1, LEVEL_W'(15));
        queue_cmd(CMD_ADD, '0, LEVEL_W'(4));
        queue_cmd(CMD_ADD, '0, LEVEL_W'(8));
        queue_cmd(CMD_ADD, ID_W'(32'h5555_5555), LEVEL_LO);
        queue_cmd(CMD_ADD, ID_W'(32'h2AAA_AAAA), LEVEL_LO);
        queue_cmd(CMD_ADD, ID_W'(32'h0000_00A5), LEVEL_HI);
        queue_cmd(CMD_ADD, ID_W'(32'h0000_005A), LEVEL_HI);
        for (int i = 0; i < 7; i++) queue_cmd(CMD_REMOVE, '0, '0);
        queue_cmd(CMD_ADD, ID_W'(32'h1234_5678), LEVEL_HI);
        queue_cmd(CMD_REMOVE, '0, '0);

        // Random traffic, then fill with a long reorder, reject while full
        queue_mix(150, 60);
        while (gen_count < DEPTH_Q - 1)
            queue_cmd(CMD_ADD, ID_W'($urandom()), pick_level(90, 5));
        queue_cmd(CMD_ADD, ID_W'($urandom()), LEVEL_HI);
        queue_cmd(CMD_ADD, ID_W'($urandom()), LEVEL_HI);
        queue_cmd(CMD_ADD, ID_W'($urandom()), LEVEL_W'(0));
        queue_cmd(CMD_ADD, ID_W'($urandom()), LEVEL_LO);
        queue_cmd(CMD_REMOVE, '0, '0);
        queue_cmd(CMD_ADD, ID_W'($urandom()), LEVEL_HI);
        queue_cmd(CMD_ADD, ID_W'($urandom()), LEVEL_W'(7));
        queue_mix(120, 40);
        // Drain past empty, then mixed traffic to the end
        while (gen_count > 0) queue_cmd(CMD_REMOVE, ID_W'($urandom()), LEVEL_W'($urandom()));
        queue_cmd(CMD_REMOVE, '0, '0);
        queue_cmd(CMD_REMOVE, '1, '1);
        while (cmds_pending.size() < RANDOM_ITEMS + 20) queue_mix(1, 55);

        cycle_limit = cmds_pending.size() * (DEPTH_Q + 8) * 4 + 1000;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_pending.size() > 0 || i_start) @(posedge i_clk);
        while (results_due.size() > 0) @(posedge i_clk);
        repeat (DEPTH_Q + 8) @(posedge i_clk);

        $display("checked %0d results: %0d added, %0d removed, %0d full, %0d bad priority, %0d empty",
                 checked_count, adds_done, removes_done, full_hits, badpri_hits, empty_hits);
        $display("peak fill %0d of %0d, longest reorder %0d entries, %0d mismatches",
                 max_fill, DEPTH_Q, max_shift, mismatch_count);
        if (mismatch_count == 0) begin
            $display("two_level_priority_queue regression: pass");
        end else begin
            $display("two_level_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
